@@ hw/rtl/ftc_pkg.sv @@
package ftc_pkg;

   localparam int FLOW_ENTRIES = 256;
   localparam int IDX_W        = $clog2(FLOW_ENTRIES);
   localparam int CNT_W        = $clog2(FLOW_ENTRIES + 1);
   localparam int FLOW_W       = 9;
   localparam int PKT_W        = 32;
   localparam int BYTE_W       = 40;

   localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;
   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [31:0] ports;
      logic [7:0]  proto;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // flow count reported on a 9-bit field, held at its top value
   function automatic logic [FLOW_W-1:0] cap_flow(input logic [CNT_W-1:0] value);
      logic [FLOW_W-1:0] result;
      if (CNT_W > FLOW_W && value > CNT_W'((1 << FLOW_W) - 1)) begin
         result = '1;
      end else begin
         result = FLOW_W'(value);
      end
      return result;
   endfunction

endpackage

@@ hw/rtl/ftc_req_if.sv @@
interface ftc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] eth_type;
   logic [7:0]  ip_protocol;
   logic [31:0] src_ip;
   logic [31:0] dst_ip;
   logic [15:0] src_port;
   logic [15:0] dst_port;
   logic [15:0] frame_length;

   modport source (
      output valid, eth_type, ip_protocol, src_ip, dst_ip, src_port, dst_port,
             frame_length,
      input  ready
   );

   modport sink (
      input  valid, eth_type, ip_protocol, src_ip, dst_ip, src_port, dst_port,
             frame_length,
      output ready
   );
endinterface

@@ hw/rtl/ftc_rsp_if.sv @@
interface ftc_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_new_flow;
   logic        table_full;
   logic [8:0]  flows_seen;
   logic [8:0]  tcp_flows_seen;
   logic [8:0]  udp_flows_seen;
   logic [31:0] packets_seen;
   logic [31:0] tcp_packets_seen;
   logic [31:0] udp_packets_seen;
   logic [39:0] tcp_bytes_seen;
   logic [39:0] udp_bytes_seen;

   modport source (
      output valid, is_new_flow, table_full, flows_seen, tcp_flows_seen, udp_flows_seen,
             packets_seen, tcp_packets_seen, udp_packets_seen, tcp_bytes_seen,
             udp_bytes_seen,
      input  ready
   );

   modport sink (
      input  valid, is_new_flow, table_full, flows_seen, tcp_flows_seen, udp_flows_seen,
             packets_seen, tcp_packets_seen, udp_packets_seen, tcp_bytes_seen,
             udp_bytes_seen,
      output ready
   );
endinterface

@@ hw/rtl/ftc_ram.sv @@
module ftc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/flow_table_traffic_counter_top.sv @@
// Flow table with traffic counters. Every packet summary taken on req_if yields one transfer
// on rsp_if with the running totals after that packet. TCP and UDP packets with an IPv4 or
// IPv6 ethertype add their frame length to the byte total of their protocol and are looked up
// in a five-tuple table held in one single-port-read RAM, searched one stored entry per cycle.
// A tracked packet searches the stored flows in order and stops early on a hit; any other
// packet skips the search. A new request is taken only once the previous one has finished.
// A new flow is appended while the table has room, otherwise it is reported with table_full.
// A waiting response does not block the next request: the response sits in its own output
// register. No clearing pass is needed after reset.
module flow_table_traffic_counter_top
   import ftc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ftc_req_if.sink   req_if,
   ftc_rsp_if.source rsp_if
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   entry_type         key_ff, key_in;
   logic              is_tcp_ff, is_tcp_in;
   logic [CNT_W-1:0]  issue_idx_ff, issue_idx_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic              miss_ff, miss_in;

   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  tcp_flows_ff, tcp_flows_in;
   logic [CNT_W-1:0]  udp_flows_ff, udp_flows_in;
   logic [PKT_W-1:0]  pkt_ff, pkt_in;
   logic [PKT_W-1:0]  tcp_pkt_ff, tcp_pkt_in;
   logic [PKT_W-1:0]  udp_pkt_ff, udp_pkt_in;
   logic [BYTE_W-1:0] tcp_byte_ff, tcp_byte_in;
   logic [BYTE_W-1:0] udp_byte_ff, udp_byte_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_new_ff, rsp_new_in;
   logic              rsp_full_ff, rsp_full_in;
   logic [FLOW_W-1:0] rsp_flows_ff, rsp_flows_in;
   logic [FLOW_W-1:0] rsp_tcp_flows_ff, rsp_tcp_flows_in;
   logic [FLOW_W-1:0] rsp_udp_flows_ff, rsp_udp_flows_in;
   logic [PKT_W-1:0]  rsp_pkt_ff, rsp_pkt_in;
   logic [PKT_W-1:0]  rsp_tcp_pkt_ff, rsp_tcp_pkt_in;
   logic [PKT_W-1:0]  rsp_udp_pkt_ff, rsp_udp_pkt_in;
   logic [BYTE_W-1:0] rsp_tcp_byte_ff, rsp_tcp_byte_in;
   logic [BYTE_W-1:0] rsp_udp_byte_ff, rsp_udp_byte_in;

   logic              accept;
   logic              req_tcp;
   logic              req_udp;
   logic              req_track;
   entry_type         req_key;
   logic [BYTE_W:0]   tcp_byte_sum;
   logic [BYTE_W:0]   udp_byte_sum;
   logic              ram_re;
   logic              ram_we;
   entry_type         ram_rdata;
   logic              match;
   logic              rsp_free;
   logic              room;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;

   assign req_tcp   = (req_if.ip_protocol == PROTO_TCP);
   assign req_udp   = (req_if.ip_protocol == PROTO_UDP);
   assign req_track = (req_tcp || req_udp) &&
                      (req_if.eth_type == ETH_TYPE_IPV4 || req_if.eth_type == ETH_TYPE_IPV6);

   assign req_key.src_addr = req_if.src_ip;
   assign req_key.dst_addr = req_if.dst_ip;
   assign req_key.ports    = {req_if.src_port, req_if.dst_port};
   assign req_key.proto    = req_if.ip_protocol;

   assign tcp_byte_sum = {1'b0, tcp_byte_ff} + (BYTE_W + 1)'(req_if.frame_length);
   assign udp_byte_sum = {1'b0, udp_byte_ff} + (BYTE_W + 1)'(req_if.frame_length);

   assign ram_re   = (state_ff == ST_SEARCH) && (issue_idx_ff != fill_ff);
   assign match    = cmp_valid_ff && (ram_rdata == key_ff);
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign room     = (fill_ff != CNT_W'(FLOW_ENTRIES));
   assign ram_we   = (state_ff == ST_FINISH) && rsp_free && miss_ff && room;

   ftc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (FLOW_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff[IDX_W-1:0]),
      .wr_data (key_ff),
      .rd_en   (ram_re),
      .rd_addr (issue_idx_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in         = state_ff;
      key_in           = key_ff;
      is_tcp_in        = is_tcp_ff;
      issue_idx_in     = issue_idx_ff;
      cmp_valid_in     = 1'b0;
      miss_in          = miss_ff;
      fill_in          = fill_ff;
      tcp_flows_in     = tcp_flows_ff;
      udp_flows_in     = udp_flows_ff;
      pkt_in           = pkt_ff;
      tcp_pkt_in       = tcp_pkt_ff;
      udp_pkt_in       = udp_pkt_ff;
      tcp_byte_in      = tcp_byte_ff;
      udp_byte_in      = udp_byte_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_if.ready;
      rsp_new_in       = rsp_new_ff;
      rsp_full_in      = rsp_full_ff;
      rsp_flows_in     = rsp_flows_ff;
      rsp_tcp_flows_in = rsp_tcp_flows_ff;
      rsp_udp_flows_in = rsp_udp_flows_ff;
      rsp_pkt_in       = rsp_pkt_ff;
      rsp_tcp_pkt_in   = rsp_tcp_pkt_ff;
      rsp_udp_pkt_in   = rsp_udp_pkt_ff;
      rsp_tcp_byte_in  = rsp_tcp_byte_ff;
      rsp_udp_byte_in  = rsp_udp_byte_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in       = req_key;
               is_tcp_in    = req_tcp;
               issue_idx_in = '0;
               miss_in      = 1'b0;
               if (pkt_ff != '1) begin
                  pkt_in = pkt_ff + 1'b1;
               end
               if (req_tcp && tcp_pkt_ff != '1) begin
                  tcp_pkt_in = tcp_pkt_ff + 1'b1;
               end
               if (req_udp && udp_pkt_ff != '1) begin
                  udp_pkt_in = udp_pkt_ff + 1'b1;
               end
               if (req_track && req_tcp) begin
                  tcp_byte_in = tcp_byte_sum[BYTE_W] ? '1 : tcp_byte_sum[BYTE_W-1:0];
               end
               if (req_track && req_udp) begin
                  udp_byte_in = udp_byte_sum[BYTE_W] ? '1 : udp_byte_sum[BYTE_W-1:0];
               end
               state_in = req_track ? ST_SEARCH : ST_FINISH;
            end
         end
         ST_SEARCH: begin
            // one read issued per cycle, compared in the cycle after it is issued
            issue_idx_in = issue_idx_ff + CNT_W'(ram_re);
            cmp_valid_in = ram_re;
            if (match) begin
               state_in = ST_FINISH;
            end else if (issue_idx_ff == fill_ff) begin
               miss_in  = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_new_in  = 1'b0;
               rsp_full_in = 1'b0;
               if (miss_ff) begin
                  if (room) begin
                     fill_in    = fill_ff + 1'b1;
                     rsp_new_in = 1'b1;
                     if (is_tcp_ff) begin
                        tcp_flows_in = tcp_flows_ff + 1'b1;
                     end else begin
                        udp_flows_in = udp_flows_ff + 1'b1;
                     end
                  end else begin
                     rsp_full_in = 1'b1;
                  end
               end
               rsp_valid_in     = 1'b1;
               rsp_flows_in     = cap_flow(fill_in);
               rsp_tcp_flows_in = cap_flow(tcp_flows_in);
               rsp_udp_flows_in = cap_flow(udp_flows_in);
               rsp_pkt_in       = pkt_ff;
               rsp_tcp_pkt_in   = tcp_pkt_ff;
               rsp_udp_pkt_in   = udp_pkt_ff;
               rsp_tcp_byte_in  = tcp_byte_ff;
               rsp_udp_byte_in  = udp_byte_ff;
               miss_in          = 1'b0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_valid_ff <= 1'b0;
         miss_ff      <= 1'b0;
         fill_ff      <= '0;
         tcp_flows_ff <= '0;
         udp_flows_ff <= '0;
         pkt_ff       <= '0;
         tcp_pkt_ff   <= '0;
         udp_pkt_ff   <= '0;
         tcp_byte_ff  <= '0;
         udp_byte_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= cmp_valid_in;
         miss_ff      <= miss_in;
         fill_ff      <= fill_in;
         tcp_flows_ff <= tcp_flows_in;
         udp_flows_ff <= udp_flows_in;
         pkt_ff       <= pkt_in;
         tcp_pkt_ff   <= tcp_pkt_in;
         udp_pkt_ff   <= udp_pkt_in;
         tcp_byte_ff  <= tcp_byte_in;
         udp_byte_ff  <= udp_byte_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff           <= key_in;
      is_tcp_ff        <= is_tcp_in;
      issue_idx_ff     <= issue_idx_in;
      rsp_new_ff       <= rsp_new_in;
      rsp_full_ff      <= rsp_full_in;
      rsp_flows_ff     <= rsp_flows_in;
      rsp_tcp_flows_ff <= rsp_tcp_flows_in;
      rsp_udp_flows_ff <= rsp_udp_flows_in;
      rsp_pkt_ff       <= rsp_pkt_in;
      rsp_tcp_pkt_ff   <= rsp_tcp_pkt_in;
      rsp_udp_pkt_ff   <= rsp_udp_pkt_in;
      rsp_tcp_byte_ff  <= rsp_tcp_byte_in;
      rsp_udp_byte_ff  <= rsp_udp_byte_in;
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.is_new_flow      = rsp_new_ff;
   assign rsp_if.table_full       = rsp_full_ff;
   assign rsp_if.flows_seen       = rsp_flows_ff;
   assign rsp_if.tcp_flows_seen   = rsp_tcp_flows_ff;
   assign rsp_if.udp_flows_seen   = rsp_udp_flows_ff;
   assign rsp_if.packets_seen     = rsp_pkt_ff;
   assign rsp_if.tcp_packets_seen = rsp_tcp_pkt_ff;
   assign rsp_if.udp_packets_seen = rsp_udp_pkt_ff;
   assign rsp_if.tcp_bytes_seen   = rsp_tcp_byte_ff;
   assign rsp_if.udp_bytes_seen   = rsp_udp_byte_ff;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(FLOW_ENTRIES))
      else $error("flow table fill count beyond depth");

   a_flow_sum: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, tcp_flows_ff} + {1'b0, udp_flows_ff}) == {1'b0, fill_ff})
      else $error("per-protocol flow counts do not add up to fill count");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_re |-> (issue_idx_ff < fill_ff))
      else $error("table read beyond stored entries");

   a_write_on_miss: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> (rsp_valid_ff && rsp_new_ff && !rsp_full_ff))
      else $error("table write without new flow response");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_new_ff && rsp_full_ff))
      else $error("new flow and table full flagged together");
`endif

endmodule

@@ sim/tb_flow_table_traffic_counter_top.sv @@
`timescale 1ns / 100ps

module tb_flow_table_traffic_counter_top;
   import ftc_pkg::*;

   localparam int HOLD_CYCLES = 1500;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct {
      logic [15:0] eth_type;
      logic [7:0]  ip_protocol;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] frame_length;
   } packet_summary_type;

   typedef struct {
      logic              is_new_flow;
      logic              table_full;
      logic [FLOW_W-1:0] flows_seen;
      logic [FLOW_W-1:0] tcp_flows_seen;
      logic [FLOW_W-1:0] udp_flows_seen;
      logic [PKT_W-1:0]  packets_seen;
      logic [PKT_W-1:0]  tcp_packets_seen;
      logic [PKT_W-1:0]  udp_packets_seen;
      logic [BYTE_W-1:0] tcp_bytes_seen;
      logic [BYTE_W-1:0] udp_bytes_seen;
   } totals_type;

   logic clock;
   logic reset;

   ftc_req_if req_bus ();
   ftc_rsp_if rsp_bus ();

   flow_table_traffic_counter_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // predicted block state
   logic [103:0]      flow_keys[$];
   int                tcp_flow_cnt = 0;
   int                udp_flow_cnt = 0;
   logic [PKT_W-1:0]  pkt_cnt      = '0;
   logic [PKT_W-1:0]  tcp_pkt_cnt  = '0;
   logic [PKT_W-1:0]  udp_pkt_cnt  = '0;
   logic [BYTE_W-1:0] tcp_byte_cnt = '0;
   logic [BYTE_W-1:0] udp_byte_cnt = '0;

   packet_summary_type packets_to_send[$];
   packet_summary_type flow_pool[$];
   totals_type         totals_due[$];
   packet_summary_type offered;

   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   bit          hold_on        = 1'b0;
   int unsigned hold_count     = 0;
   int unsigned cycle_count    = 0;
   int          mismatches     = 0;

   function automatic logic [PKT_W-1:0] bump(input logic [PKT_W-1:0] n);
      return (n == '1) ? n : n + 1'b1;
   endfunction

   function automatic logic [BYTE_W-1:0] add_bytes(input logic [BYTE_W-1:0] acc,
                                                   input logic [15:0] len);
      logic [BYTE_W:0] sum;
      sum = {1'b0, acc} + len;
      return sum[BYTE_W] ? '1 : sum[BYTE_W-1:0];
   endfunction

   function automatic logic [FLOW_W-1:0] flow_field(input int n);
      return (n > (1 << FLOW_W) - 1) ? '1 : FLOW_W'(n);
   endfunction

   function automatic totals_type count_packet(input packet_summary_type p);
      totals_type   t;
      logic         tcp;
      logic         udp;
      logic         known;
      logic [103:0] key;
      tcp = (p.ip_protocol == PROTO_TCP);
      udp = (p.ip_protocol == PROTO_UDP);
      key = {p.src_ip, p.dst_ip, p.src_port, p.dst_port, p.ip_protocol};
      t.is_new_flow = 1'b0;
      t.table_full  = 1'b0;
      pkt_cnt = bump(pkt_cnt);
      if (tcp) tcp_pkt_cnt = bump(tcp_pkt_cnt);
      if (udp) udp_pkt_cnt = bump(udp_pkt_cnt);
      if ((tcp || udp) &&
          (p.eth_type == ETH_TYPE_IPV4 || p.eth_type == ETH_TYPE_IPV6)) begin
         if (tcp) begin
            tcp_byte_cnt = add_bytes(tcp_byte_cnt, p.frame_length);
         end else begin
            udp_byte_cnt = add_bytes(udp_byte_cnt, p.frame_length);
         end
         known = 1'b0;
         foreach (flow_keys[i]) begin
            if (flow_keys[i] == key) known = 1'b1;
         end
         if (!known) begin
            if (flow_keys.size() < FLOW_ENTRIES) begin
               flow_keys.push_back(key);
               if (tcp) tcp_flow_cnt++;
               else udp_flow_cnt++;
               t.is_new_flow = 1'b1;
            end else begin
               t.table_full = 1'b1;
            end
         end
      end
      t.flows_seen       = flow_field(flow_keys.size());
      t.tcp_flows_seen   = flow_field(tcp_flow_cnt);
      t.udp_flows_seen   = flow_field(udp_flow_cnt);
      t.packets_seen     = pkt_cnt;
      t.tcp_packets_seen = tcp_pkt_cnt;
      t.udp_packets_seen = udp_pkt_cnt;
      t.tcp_bytes_seen   = tcp_byte_cnt;
      t.udp_bytes_seen   = udp_byte_cnt;
      return t;
   endfunction

   function automatic void queue_packet(input logic [15:0] et, input logic [7:0] proto,
                                        input logic [31:0] sa, input logic [31:0] da,
                                        input logic [15:0] sp, input logic [15:0] dp,
                                        input logic [15:0] len);
      packet_summary_type p;
      p.eth_type     = et;
      p.ip_protocol  = proto;
      p.src_ip       = sa;
      p.dst_ip       = da;
      p.src_port     = sp;
      p.dst_port     = dp;
      p.frame_length = len;
      packets_to_send.push_back(p);
   endfunction

   function automatic packet_summary_type make_packet();
      packet_summary_type p;
      int unsigned        pick;
      pick = $urandom_range(99);
      p.eth_type     = 16'($urandom());
      p.ip_protocol  = 8'($urandom());
      p.src_ip       = $urandom();
      p.dst_ip       = $urandom();
      p.src_port     = 16'($urandom());
      p.dst_port     = 16'($urandom());
      p.frame_length = 16'($urandom());
      if (pick < 80) begin
         if (flow_pool.size() != 0 && $urandom_range(99) < 50) begin
            // repeat a flow already sent
            p = flow_pool[$urandom_range(flow_pool.size() - 1)];
            p.frame_length = 16'($urandom());
         end else begin
            if (flow_pool.size() != 0 && $urandom_range(1) == 1) begin
               // near neighbor of a known flow
               p = flow_pool[$urandom_range(flow_pool.size() - 1)];
               p.frame_length = 16'($urandom());
               case ($urandom_range(4))
                  0: p.src_ip   ^= 32'(1) << $urandom_range(31);
                  1: p.dst_ip   ^= 32'(1) << $urandom_range(31);
                  2: p.src_port ^= 16'(1) << $urandom_range(15);
                  3: p.dst_port ^= 16'(1) << $urandom_range(15);
                  default: begin
                     p.ip_protocol = (p.ip_protocol == PROTO_TCP) ? PROTO_UDP : PROTO_TCP;
                  end
               endcase
            end else begin
               p.ip_protocol = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
            end
            flow_pool.push_back(p);
         end
         p.eth_type = $urandom_range(1) ? ETH_TYPE_IPV4 : ETH_TYPE_IPV6;
         if (pick >= 70) begin
            // rejected ethertype one bit away from an accepted one
            p.eth_type ^= 16'(1) << $urandom_range(15);
         end
      end else if (pick < 90) begin
         while (p.ip_protocol == PROTO_TCP || p.ip_protocol == PROTO_UDP) begin
            p.ip_protocol = 8'($urandom());
         end
         if ($urandom_range(1) == 1) begin
            p.eth_type = $urandom_range(1) ? ETH_TYPE_IPV4 : ETH_TYPE_IPV6;
         end
      end
      return p;
   endfunction

   task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                              input logic [BYTE_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch on %s: expected %0h, got %0h", name, want, got);
         end
      end
   endtask

   task automatic run_phase(input int n, input int idle, input int stall, input bit long_hold);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      hold_on        = long_hold;
      repeat (n) packets_to_send.push_back(make_packet());
      while (hold_on && hold_count < HOLD_CYCLES) @(negedge clock);
      hold_on = 1'b0;
      while (packets_to_send.size() != 0 || req_bus.valid || totals_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // request driver
   always @(posedge clock) begin : req_driver
      packet_summary_type p;
      if (reset) begin
         req_bus.valid        <= 1'b0;
         req_bus.eth_type     <= '0;
         req_bus.ip_protocol  <= '0;
         req_bus.src_ip       <= '0;
         req_bus.dst_ip       <= '0;
         req_bus.src_port     <= '0;
         req_bus.dst_port     <= '0;
         req_bus.frame_length <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            totals_due.push_back(count_packet(offered));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (packets_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               p = packets_to_send.pop_front();
               req_bus.eth_type     <= p.eth_type;
               req_bus.ip_protocol  <= p.ip_protocol;
               req_bus.src_ip       <= p.src_ip;
               req_bus.dst_ip       <= p.dst_ip;
               req_bus.src_port     <= p.src_port;
               req_bus.dst_port     <= p.dst_port;
               req_bus.frame_length <= p.frame_length;
               offered              <= p;
               req_bus.valid        <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_on) begin
         hold_count <= hold_count + 1;
      end else begin
         hold_count <= 0;
      end
   end

   // response monitor
   always @(posedge clock) begin : rsp_monitor
      totals_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (totals_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("response transfer with no packet pending");
            end else begin
               want = totals_due.pop_front();
               check_field("is_new_flow", want.is_new_flow, rsp_bus.is_new_flow);
               check_field("table_full", want.table_full, rsp_bus.table_full);
               check_field("flows_seen", want.flows_seen, rsp_bus.flows_seen);
               check_field("tcp_flows_seen", want.tcp_flows_seen, rsp_bus.tcp_flows_seen);
               check_field("udp_flows_seen", want.udp_flows_seen, rsp_bus.udp_flows_seen);
               check_field("packets_seen", want.packets_seen, rsp_bus.packets_seen);
               check_field("tcp_packets_seen", want.tcp_packets_seen,
                           rsp_bus.tcp_packets_seen);
               check_field("udp_packets_seen", want.udp_packets_seen,
                           rsp_bus.udp_packets_seen);
               check_field("tcp_bytes_seen", want.tcp_bytes_seen, rsp_bus.tcp_bytes_seen);
               check_field("udp_bytes_seen", want.udp_bytes_seen, rsp_bus.udp_bytes_seen);
            end
         end
         rsp_bus.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : stimulus
      while (reset) @(negedge clock);

      // tracked flows, known flows and protocol pairs
      queue_packet(ETH_TYPE_IPV4, PROTO_TCP, '0, '0, '0, '0, 16'd0);
      queue_packet(ETH_TYPE_IPV4, PROTO_TCP, '0, '0, '0, '0, 16'hFFFF);
      queue_packet(ETH_TYPE_IPV6, PROTO_UDP, '0, '0, '0, '0, 16'd1);
      queue_packet(ETH_TYPE_IPV6, PROTO_TCP, '0, '0, '0, '0, 16'd100);
      queue_packet(ETH_TYPE_IPV6, PROTO_TCP, '1, '1, '1, '1, 16'hFFFF);
      queue_packet(ETH_TYPE_IPV4, PROTO_UDP, '1, '1, '1, '1, 16'hFFFF);
      queue_packet(ETH_TYPE_IPV4, PROTO_TCP, 32'h0A000001, 32'h0A000002, 16'd1234,
                   16'd80, 16'd60);
      queue_packet(ETH_TYPE_IPV4, PROTO_TCP, 32'h0A000002, 32'h0A000001, 16'd80,
                   16'd1234, 16'd60);
      queue_packet(ETH_TYPE_IPV4, PROTO_TCP, 32'h0A000001, 32'h0A000002, 16'd1234,
                   16'd81, 16'd60);
      queue_packet(ETH_TYPE_IPV6, PROTO_TCP, 32'h0A000001, 32'h0A000002, 16'd1234,
                   16'd80, 16'd1500);
      // rejected ethertypes
      queue_packet(16'h0801, PROTO_TCP, 32'h1, 32'h2, 16'd3, 16'd4, 16'd500);
      queue_packet(16'h86DC, PROTO_UDP, 32'h1, 32'h2, 16'd3, 16'd4, 16'd500);
      queue_packet(16'h0000, PROTO_UDP, '0, '0, '0, '0, 16'hFFFF);
      queue_packet(16'hFFFF, PROTO_TCP, '1, '1, '1, '1, 16'hFFFF);
      // other protocols
      queue_packet(ETH_TYPE_IPV4, 8'd0,   '0, '0, '0, '0, 16'd64);
      queue_packet(ETH_TYPE_IPV6, 8'd255, '1, '1, '1, '1, 16'hFFFF);
      queue_packet(ETH_TYPE_IPV4, 8'd5,   32'h1, 32'h2, 16'd3, 16'd4, 16'd64);
      queue_packet(ETH_TYPE_IPV4, 8'd7,   32'h1, 32'h2, 16'd3, 16'd4, 16'd64);
      queue_packet(ETH_TYPE_IPV4, 8'd16,  32'h1, 32'h2, 16'd3, 16'd4, 16'd64);
      queue_packet(ETH_TYPE_IPV4, 8'd18,  32'h1, 32'h2, 16'd3, 16'd4, 16'd64);
      run_phase(0, 0, 0, 1'b0);

      run_phase(450, 0, 0, 1'b0);
      run_phase(60, 0, 0, 1'b1);
      run_phase(450, 64, 0, 1'b0);
      run_phase(450, 0, 64, 1'b0);
      run_phase(450, 29, 29, 1'b0);

      repeat (300) @(negedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
